### design/vpw_pkg.sv
package vpw_pkg;

    localparam int WORD_W    = 32;
    localparam int IDX_W     = 4;
    localparam int MAT_DEPTH = 16;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int SATW      = 72;
    localparam int LANES     = 3;
    localparam int IN_DATA_W  = 136;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VP_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VP_H = 2'd3;

    localparam logic MAT_MODELVIEW  = 1'b0;
    localparam logic MAT_PROJECTION = 1'b1;

    localparam logic signed [SATW-1:0] SAT_HI = {{(SATW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [SATW-1:0] SAT_LO = {{(SATW-31){1'b1}}, 31'd0};

    typedef struct packed {
        logic                     valid;
        logic                     op_project;
        logic                     mat_sel;
        logic [IDX_W-1:0]         idx;
        logic signed [WORD_W-1:0] value;
    } t_load_ctl;

    typedef struct packed {
        logic             valid;
        logic             w_zero;
        logic [LANES-1:0] neg;
    } t_div_ctl;

    typedef struct packed {
        logic                     w_zero;
        logic signed [WORD_W-1:0] wz;
        logic signed [WORD_W-1:0] wy;
        logic signed [WORD_W-1:0] wx;
    } t_result;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SATW-1:0] v);
        if (v > SAT_HI) begin
            return 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            return 32'sh8000_0000;
        end else begin
            return v[WORD_W-1:0];
        end
    endfunction

endpackage

### design/vpw_mat_stage.sv
module vpw_mat_stage #(
    parameter int FRAC_BITS = 16,
    parameter bit MAT_SEL   = 1'b0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  vpw_pkg::t_load_ctl  i_ctl,
    input  logic signed [31:0]  i_vec [4],
    output vpw_pkg::t_load_ctl  o_ctl,
    output logic signed [31:0]  o_vec [4]
);
    import vpw_pkg::*;

    logic signed [WORD_W-1:0] r_store [MAT_DEPTH];
    logic signed [PROD_W-1:0] r_prod  [MAT_DEPTH];
    logic signed [PROD_W-1:0] n_prod  [MAT_DEPTH];
    logic signed [SUM_W-1:0]  r_sum   [4];
    logic signed [SUM_W-1:0]  n_sum   [4];
    logic signed [WORD_W-1:0] r_vec   [4];
    logic signed [WORD_W-1:0] n_vec   [4];
    t_load_ctl                r_ctl1, r_ctl2, r_ctl3;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                n_prod[r*4+c] = r_store[r*4+c] * i_vec[c];
            end
            n_sum[r] = SUM_W'(r_prod[r*4]) + SUM_W'(r_prod[r*4+1])
                     + SUM_W'(r_prod[r*4+2]) + SUM_W'(r_prod[r*4+3]);
            n_vec[r] = sat32(SATW'(r_sum[r] >>> FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.valid && !i_ctl.op_project && (i_ctl.mat_sel == MAT_SEL)) begin
            r_store[i_ctl.idx] <= i_ctl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else if (i_adv) begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_ctl3 <= r_ctl2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod <= n_prod;
            r_sum  <= n_sum;
            r_vec  <= n_vec;
        end
    end

    assign o_ctl = r_ctl3;
    assign o_vec = r_vec;

endmodule

### design/vpw_div_cell.sv
module vpw_div_cell #(
    parameter int QW = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  vpw_pkg::t_div_ctl i_ctl,
    input  logic [31:0]       i_den,
    input  logic [31:0]       i_rem [3],
    input  logic [QW-1:0]     i_num [3],
    output vpw_pkg::t_div_ctl o_ctl,
    output logic [31:0]       o_den,
    output logic [31:0]       o_rem [3],
    output logic [QW-1:0]     o_num [3]
);
    import vpw_pkg::*;

    logic [WORD_W:0]   w_trial [LANES];
    logic [LANES-1:0]  w_ge;
    logic [WORD_W-1:0] n_rem   [LANES];
    logic [QW-1:0]     n_num   [LANES];
    t_div_ctl          r_ctl;
    logic [WORD_W-1:0] r_den;
    logic [WORD_W-1:0] r_rem   [LANES];
    logic [QW-1:0]     r_num   [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_trial[l] = {i_rem[l], i_num[l][QW-1]};
            w_ge[l]    = w_trial[l] >= {1'b0, i_den};
            n_rem[l]   = w_ge[l] ? WORD_W'(w_trial[l] - {1'b0, i_den}) : w_trial[l][WORD_W-1:0];
            n_num[l]   = {i_num[l][QW-2:0], w_ge[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_den <= i_den;
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_ctl = r_ctl;
    assign o_den = r_den;
    assign o_rem = r_rem;
    assign o_num = r_num;

endmodule

### design/vertex_project_to_window_top.sv
// Projects world-space points to window coordinates, one item per cycle.
// Input stream: tuser[0] operation (0 load, 1 project), tuser[1] matrix select;
// tdata carries element index, element value and point x, y, z (Q16.16).
// A load writes one element of the model-view or projection matrix and gives
// no result; it takes effect for every project item that follows it.
// Output stream: tdata window x, y, depth; tuser[0] flags a zero clip w, with
// all coordinates zero.
// A project item passes the input register, the multiply, add and saturate
// registers of both matrix stages, one divider setup stage, a chain of
// 32 + FRAC_BITS divider cells retiring one quotient bit each, three viewport
// stages and the output register.
// Throughput is one item per cycle, load and project alike, with the skid empty.
// Configuration writes via i_cfg_we / i_cfg_index / i_cfg_wdata are for the
// user to make while idle; the block does not check. Reset clears the viewport
// registers and flushes the pipeline; matrices hold nothing valid until loaded.
// When the receiver stalls, the result waits in the output register and one
// more is caught in a skid register; the pipeline and s_axis_tready hold
// while the skid register is full.
module vertex_project_to_window_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [vpw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vpw_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // element_index, element_value, point_x, point_y, point_z, zero pad
    input  logic [vpw_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // operation, matrix_select
    input  logic [vpw_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // window_x, window_y, window_depth
    output logic [vpw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // w_was_zero
    output logic [vpw_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import vpw_pkg::*;

    localparam int QW = WORD_W + FRAC_BITS;
    localparam logic signed [WORD_W-1:0] ONE_W   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [WORD_W:0]   ONE_33  = 33'sd1 <<< FRAC_BITS;

    logic                     w_adv;
    logic signed [15:0]       r_vp_x, r_vp_y;
    logic [14:0]              r_vp_w, r_vp_h;

    t_load_ctl                r_in_ctl;
    logic signed [WORD_W-1:0] r_pt  [3];
    logic signed [WORD_W-1:0] w_pt  [4];
    t_load_ctl                w_eye_ctl, w_clip_ctl;
    logic signed [WORD_W-1:0] w_eye [4];
    logic signed [WORD_W-1:0] w_clip [4];

    t_div_ctl                 n_div_ctl;
    logic [WORD_W-1:0]        n_den;
    logic [QW-1:0]            n_num [LANES];
    logic [WORD_W-1:0]        w_mag [4];

    t_div_ctl                 w_ctl [QW+1];
    logic [WORD_W-1:0]        w_den [QW+1];
    logic [WORD_W-1:0]        w_rem [QW+1][LANES];
    logic [QW-1:0]            w_num [QW+1][LANES];
    logic [WORD_W-1:0]        w_rem0 [LANES];

    t_div_ctl                 r_p1_ctl, r_p2_ctl;
    logic signed [WORD_W-1:0] r_t  [LANES];
    logic signed [WORD_W-1:0] n_t  [LANES];
    logic signed [WORD_W-1:0] w_ndc [LANES];
    logic signed [WORD_W:0]   w_tsum [LANES];
    logic signed [47:0]       r_prod_x, r_prod_y;
    logic signed [WORD_W-1:0] r_p2_z;
    logic                     r_p3_valid;
    t_result                  r_p3, n_p3;

    logic                     r_out_valid, r_skid_valid;
    t_result                  r_out, r_skid;
    logic                     w_pop, w_push;

    assign w_adv         = !r_skid_valid;
    assign s_axis_tready = i_rst_n && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp_x <= '0;
            r_vp_y <= '0;
            r_vp_w <= '0;
            r_vp_h <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_VP_X: r_vp_x <= $signed(i_cfg_wdata);
                CFG_VP_Y: r_vp_y <= $signed(i_cfg_wdata);
                CFG_VP_W: r_vp_w <= i_cfg_wdata[14:0];
                CFG_VP_H: r_vp_h <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_adv) begin
            r_in_ctl.valid      <= s_axis_tvalid;
            r_in_ctl.op_project <= s_axis_tuser[0];
            r_in_ctl.mat_sel    <= s_axis_tuser[1];
            r_in_ctl.idx        <= s_axis_tdata[3:0];
            r_in_ctl.value      <= $signed(s_axis_tdata[35:4]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pt[0] <= $signed(s_axis_tdata[67:36]);
            r_pt[1] <= $signed(s_axis_tdata[99:68]);
            r_pt[2] <= $signed(s_axis_tdata[131:100]);
        end
    end

    assign w_pt[0] = r_pt[0];
    assign w_pt[1] = r_pt[1];
    assign w_pt[2] = r_pt[2];
    assign w_pt[3] = ONE_W;

    vpw_mat_stage #(.FRAC_BITS(FRAC_BITS), .MAT_SEL(MAT_MODELVIEW)) u_modelview (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (r_in_ctl),
        .i_vec   (w_pt),
        .o_ctl   (w_eye_ctl),
        .o_vec   (w_eye)
    );

    vpw_mat_stage #(.FRAC_BITS(FRAC_BITS), .MAT_SEL(MAT_PROJECTION)) u_projection (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_eye_ctl),
        .i_vec   (w_eye),
        .o_ctl   (w_clip_ctl),
        .o_vec   (w_clip)
    );

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_mag[k] = w_clip[k][WORD_W-1] ? WORD_W'(-w_clip[k]) : WORD_W'(w_clip[k]);
        end
        n_div_ctl.valid  = w_clip_ctl.valid && w_clip_ctl.op_project;
        n_div_ctl.w_zero = (w_clip[3] == '0);
        for (int l = 0; l < LANES; l++) begin
            n_div_ctl.neg[l] = w_clip[l][WORD_W-1] ^ w_clip[3][WORD_W-1];
            n_num[l]         = QW'(w_mag[l]) << FRAC_BITS;
        end
        n_den = w_mag[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            w_ctl[0] <= '0;
        end else if (w_adv) begin
            w_ctl[0] <= n_div_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            w_den[0] <= n_den;
            w_num[0] <= n_num;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rem0[l] = '0;
        end
    end
    assign w_rem[0] = w_rem0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        vpw_div_cell #(.QW(QW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_ctl   (w_ctl[g]),
            .i_den   (w_den[g]),
            .i_rem   (w_rem[g]),
            .i_num   (w_num[g]),
            .o_ctl   (w_ctl[g+1]),
            .o_den   (w_den[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_num   (w_num[g+1])
        );
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_ndc[l]  = w_ctl[QW].neg[l] ? sat32(-SATW'(w_num[QW][l]))
                                         : sat32(SATW'(w_num[QW][l]));
            w_tsum[l] = 33'(w_ndc[l]) + ONE_33;
            n_t[l]    = WORD_W'(w_tsum[l] >>> 1);
        end
        n_p3.w_zero = r_p2_ctl.w_zero;
        if (r_p2_ctl.w_zero) begin
            n_p3.wx = '0;
            n_p3.wy = '0;
            n_p3.wz = '0;
        end else begin
            n_p3.wx = sat32((SATW'(r_vp_x) <<< FRAC_BITS) + SATW'(r_prod_x));
            n_p3.wy = sat32((SATW'(r_vp_y) <<< FRAC_BITS) + SATW'(r_prod_y));
            n_p3.wz = r_p2_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_ctl   <= '0;
            r_p2_ctl   <= '0;
            r_p3_valid <= 1'b0;
        end else if (w_adv) begin
            r_p1_ctl   <= w_ctl[QW];
            r_p2_ctl   <= r_p1_ctl;
            r_p3_valid <= r_p2_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t      <= n_t;
            r_prod_x <= r_t[0] * $signed({1'b0, r_vp_w});
            r_prod_y <= r_t[1] * $signed({1'b0, r_vp_h});
            r_p2_z   <= r_t[2];
            r_p3     <= n_p3;
        end
    end

    assign w_pop  = r_out_valid && m_axis_tready;
    assign w_push = w_adv && r_p3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= r_p3;
            end else begin
                r_skid <= r_p3;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.wz, r_out.wy, r_out.wx};
    assign m_axis_tuser  = r_out.w_zero;

endmodule

### design/vpw_checker.sv
module vpw_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [vpw_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input logic [vpw_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import vpw_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_no_accept_in_reset: assert property (@(posedge i_clk) !i_rst_n |-> !s_axis_tready)
        else $error("input ready during reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_zero_w_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("zero w item with nonzero coordinates");

    a_backpressure_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result waiting");

endmodule

bind vertex_project_to_window_top vpw_checker u_vpw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
